>>> hw/rtl/telemetry_frame_checker_defines.svh
// assertion macros for the telemetry frame checker
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef TELEMETRY_FRAME_CHECKER_DEFINES_SVH
`define TELEMETRY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tfc_pkg.sv
// shared types, constants and the byte-wide crc-32 step for the frame checker
// no dependencies
package tfc_pkg;

    localparam int unsigned HDR_LEN = 23;
    localparam int unsigned CRC_LEN = 4;
    localparam int unsigned FRAME_OVERHEAD = HDR_LEN + CRC_LEN;
    localparam int unsigned CNT_W = 17;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0] BATTERY_MAX = 8'd100;
    localparam logic [7:0] STATUS_MAX = 8'd3;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [31:0] MAGIC_RESET = 32'h53544753;
    localparam logic [7:0] VERSION_RESET = 8'd1;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // header byte positions
    localparam int unsigned POS_VERSION = 4;
    localparam int unsigned POS_SAT = 5;
    localparam int unsigned POS_TIME = 7;
    localparam int unsigned POS_TEMP = 15;
    localparam int unsigned POS_BATT = 19;
    localparam int unsigned POS_STATUS = 20;
    localparam int unsigned POS_LEN = 21;

    typedef enum logic [1:0] {
        REG_MAGIC = 2'd0,
        REG_VERSION = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ERR_OK = 4'd0,
        ERR_SHORT = 4'd1,
        ERR_MAGIC = 4'd2,
        ERR_VERSION = 4'd3,
        ERR_TOO_LARGE = 4'd4,
        ERR_LENGTH = 4'd5,
        ERR_CRC = 4'd6,
        ERR_BATTERY = 4'd7,
        ERR_STATUS = 4'd8
    } t_err_code;

    typedef struct packed {
        logic step;     // an item is taken this cycle
        logic restart;  // final byte: back to the reset values
        logic update;   // oldest delay-line byte enters the crc
    } t_crc_ctl;

    typedef struct packed {
        logic kind;
        logic [7:0] payload_byte;
        t_err_code err;
        logic [15:0] sat_id;
        logic [63:0] timestamp;
        logic [31:0] temperature;
        logic [7:0] battery;
        logic [7:0] status;
        logic [15:0] plen;
    } t_result;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/tfc_crc.sv
// crc-32 register with the four-byte delay line in front of it
// depends on tfc_pkg
module tfc_crc import tfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc_next,
    output logic [31:0] o_rx_next
);

    logic [31:0] r_crc;
    logic [7:0]  r_dly [CRC_LEN];

    assign o_crc_next = i_ctl.update ? crc32_byte(r_crc, r_dly[0]) : r_crc;
    // delay line after the shift holds the received crc, big-endian
    assign o_rx_next = {r_dly[1], r_dly[2], r_dly[3], i_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            for (int i = 0; i < CRC_LEN; i++) begin
                r_dly[i] <= 8'd0;
            end
        end else if (i_ctl.step) begin
            if (i_ctl.restart) begin
                r_crc <= CRC_INIT;
                for (int i = 0; i < CRC_LEN; i++) begin
                    r_dly[i] <= 8'd0;
                end
            end else begin
                r_crc <= o_crc_next;
                for (int i = 0; i < CRC_LEN - 1; i++) begin
                    r_dly[i] <= r_dly[i+1];
                end
                r_dly[CRC_LEN-1] <= i_byte;
            end
        end
    end

endmodule

>>> hw/rtl/telemetry_frame_checker.sv
// Telemetry frame checker: takes one frame byte per cycle unless stalled, forwards payload
// bytes and gives one verdict on the final byte, with the decoded header unless the frame
// is short. Each result is registered. The byte-wide crc-32 step and the byte counter
// sustain that rate. Results pass through an output register backed by a one-entry skid
// stage, so input stall rises only when both hold results. Depends on tfc_pkg and tfc_crc.
`include "telemetry_frame_checker_defines.svh"

module telemetry_frame_checker import tfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_frame,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_error_code,
    output logic [15:0] o_satellite_id,
    output logic [63:0] o_timestamp_ms,
    output logic [31:0] o_temperature_bits,
    output logic [7:0]  o_battery_percent,
    output logic [7:0]  o_status_value,
    output logic [15:0] o_payload_length,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_magic;
    logic [7:0]  r_version;
    logic [15:0] r_max_payload;

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_hdr [HDR_LEN];

    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid, has_res;

    logic in_acc, pop;
    t_crc_ctl    crc_ctl;
    logic [31:0] crc_next, rx_next;

    logic [31:0] hdr_magic;
    logic [15:0] hdr_plen;
    logic [CNT_W-1:0] pos_off, len_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = r_skid_valid;
    assign in_acc = i_in_valid && !r_skid_valid;
    assign pop = r_out_valid && !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
            r_version <= VERSION_RESET;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAGIC:       r_magic <= i_cfg_data;
                REG_VERSION:     r_version <= i_cfg_data[7:0];
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign crc_ctl.step = in_acc;
    assign crc_ctl.restart = i_end_of_frame;
    assign crc_ctl.update = (r_count >= CNT_W'(CRC_LEN));

    tfc_crc u_crc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (crc_ctl),
        .i_byte     (i_data_byte),
        .o_crc_next (crc_next),
        .o_rx_next  (rx_next)
    );

    assign hdr_magic = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3]};
    assign hdr_plen = {r_hdr[POS_LEN], r_hdr[POS_LEN+1]};
    assign pos_off = r_count - CNT_W'(HDR_LEN);
    // last position of a frame whose length matches the header
    assign len_end = {1'b0, hdr_plen} + CNT_W'(FRAME_OVERHEAD - 1);

    always_comb begin
        n_res = '0;
        has_res = 1'b0;
        if (i_end_of_frame) begin
            has_res = 1'b1;
            n_res.kind = 1'b1;
            if (r_count < CNT_W'(FRAME_OVERHEAD - 1)) begin
                n_res.err = ERR_SHORT;
            end else begin
                n_res.sat_id = {r_hdr[POS_SAT], r_hdr[POS_SAT+1]};
                n_res.timestamp = {r_hdr[POS_TIME], r_hdr[POS_TIME+1], r_hdr[POS_TIME+2],
                                   r_hdr[POS_TIME+3], r_hdr[POS_TIME+4], r_hdr[POS_TIME+5],
                                   r_hdr[POS_TIME+6], r_hdr[POS_TIME+7]};
                n_res.temperature = {r_hdr[POS_TEMP], r_hdr[POS_TEMP+1],
                                     r_hdr[POS_TEMP+2], r_hdr[POS_TEMP+3]};
                n_res.battery = r_hdr[POS_BATT];
                n_res.status = r_hdr[POS_STATUS];
                n_res.plen = hdr_plen;
                if (hdr_magic != r_magic) begin
                    n_res.err = ERR_MAGIC;
                end else if (r_hdr[POS_VERSION] != r_version) begin
                    n_res.err = ERR_VERSION;
                end else if (hdr_plen > r_max_payload) begin
                    n_res.err = ERR_TOO_LARGE;
                end else if (r_count != len_end) begin
                    n_res.err = ERR_LENGTH;
                end else if (rx_next != ~crc_next) begin
                    n_res.err = ERR_CRC;
                end else if (r_hdr[POS_BATT] > BATTERY_MAX) begin
                    n_res.err = ERR_BATTERY;
                end else if (r_hdr[POS_STATUS] > STATUS_MAX) begin
                    n_res.err = ERR_STATUS;
                end else begin
                    n_res.err = ERR_OK;
                end
            end
        end else if (r_count >= CNT_W'(HDR_LEN) && pos_off < {1'b0, hdr_plen}) begin
            has_res = 1'b1;
            n_res.payload_byte = i_data_byte;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_end_of_frame) begin
            n_count = '0;
        end else if (r_count != CNT_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    // byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= n_count;
        end
    end

    // header bytes, written once per frame at their own position
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CNT_W'(HDR_LEN)) begin
            r_hdr[r_count[4:0]] <= i_data_byte;
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= in_acc && has_res;
            if (in_acc && has_res) begin
                r_out <= n_res;
            end
        end else if (in_acc && has_res) begin
            r_skid <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_error_code = r_out.err;
    assign o_satellite_id = r_out.sat_id;
    assign o_timestamp_ms = r_out.timestamp;
    assign o_temperature_bits = r_out.temperature;
    assign o_battery_percent = r_out.battery;
    assign o_status_value = r_out.status;
    assign o_payload_length = r_out.plen;

    `TFC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid holds an item while the output register is empty")
    `TFC_ASSERT_NEXT(a_restart_count, in_acc && i_end_of_frame, r_count == '0, "byte counter not cleared after the final byte")
    `TFC_ASSERT_NOW(a_payload_clean, r_out_valid && !r_out.kind, r_out.err == ERR_OK && r_out.plen == '0, "payload item carries verdict fields")
    `TFC_ASSERT_NOW(a_short_zero, r_out_valid && r_out.kind && r_out.err == ERR_SHORT, r_out.sat_id == '0 && r_out.timestamp == '0 && r_out.plen == '0, "short verdict carries header fields")

endmodule
